// ===== rtl/dlt_pkg.sv =====
// shared types and constants for the debounced level trigger
// no dependencies; imported by every rtl module of the block
`default_nettype none

package dlt_pkg;

  // register file layout
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned LevelW = 16;
  localparam int unsigned DtW    = 16;
  localparam int unsigned TimeW  = 24;

  // register indexes, word address = paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_PRESS_DLY = 2'd1,
    REG_REL_DLY   = 2'd2,
    REG_ENABLE    = 2'd3
  } reg_idx_e;

  // reset values of the registers, the threshold floor and the accumulator maximum
  localparam logic [LevelW-1:0] ThreshRst   = 16'd1311;
  localparam logic [TimeW-1:0]  PressDlyRst = 24'd50000;
  localparam logic [TimeW-1:0]  RelDlyRst   = 24'd100000;
  localparam logic [LevelW-1:0] ThreshFloor = 16'd7;
  localparam logic [TimeW-1:0]  TimeMax     = {TimeW{1'b1}};

  // button phase
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_PRESSED   = 2'd1,
    PH_HELD      = 2'd2,
    PH_RELEASING = 2'd3
  } phase_e;

  // configuration seen by the trigger logic
  typedef struct packed {
    logic [LevelW-1:0] threshold_level;
    logic [TimeW-1:0]  press_delay_us;
    logic [TimeW-1:0]  release_delay_us;
    logic              enable;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic [DtW-1:0]    elapsed_us;
    logic [LevelW-1:0] level;
    logic              audio_ok;
    logic              dead;
  } item_t;

  // one result item
  typedef struct packed {
    logic   press_event;
    logic   release_event;
    logic   button_down;
    phase_e phase_out;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/debounced_level_trigger.sv =====
// debounced level trigger: input register, trigger state update, result register
// an accepted item passes the input register, then the result register, where its result waits until taken
// throughput: one item per cycle while out_ready_i does not stall the output; the state update is combinational
// reset: phase idle, accumulators and button cleared, registers at reset values
// depends on dlt_pkg, dlt_regs, dlt_fsm
`default_nettype none

module debounced_level_trigger (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // apb configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [dlt_pkg::AddrW-1:0]  paddr,
  input  wire logic [dlt_pkg::DataW-1:0]  pwdata,
  output logic      [dlt_pkg::DataW-1:0]  prdata,
  output logic                           pready,
  // input items
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [dlt_pkg::DtW-1:0]    elapsed_us_i,
  input  wire logic [dlt_pkg::LevelW-1:0] level_i,
  input  wire logic                      audio_ok_i,
  input  wire logic                      dead_i,
  // result items
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           press_event_o,
  output logic                           release_event_o,
  output logic                           button_down_o,
  output logic [1:0]                     phase_out_o
);
  import dlt_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_vld_q, out_vld_q;
  logic  adv;

  dlt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item moves from input register to result register
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.elapsed_us <= elapsed_us_i;
      item_q.level      <= level_i;
      item_q.audio_ok   <= audio_ok_i;
      item_q.dead       <= dead_i;
    end
  end

  dlt_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign press_event_o   = res_q.press_event;
  assign release_event_o = res_q.release_event;
  assign button_down_o   = res_q.button_down;
  assign phase_out_o     = res_q.phase_out;

endmodule

`default_nettype wire

// ===== rtl/dlt_regs.sv =====
// apb configuration registers of the debounced level trigger
// depends on dlt_pkg
`default_nettype none

module dlt_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [dlt_pkg::AddrW-1:0] paddr,
  input  wire logic [dlt_pkg::DataW-1:0] pwdata,
  output logic      [dlt_pkg::DataW-1:0] prdata,
  output logic                          pready,
  output dlt_pkg::cfg_t                 cfg_o
);
  import dlt_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_level  <= ThreshRst;
      cfg_q.press_delay_us   <= PressDlyRst;
      cfg_q.release_delay_us <= RelDlyRst;
      cfg_q.enable           <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD: cfg_q.threshold_level  <= pwdata[LevelW-1:0];
        REG_PRESS_DLY: cfg_q.press_delay_us   <= pwdata[TimeW-1:0];
        REG_REL_DLY:   cfg_q.release_delay_us <= pwdata[TimeW-1:0];
        REG_ENABLE:    cfg_q.enable           <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_THRESHOLD: prdata = {{(DataW-LevelW){1'b0}}, cfg_q.threshold_level};
      REG_PRESS_DLY: prdata = {{(DataW-TimeW){1'b0}}, cfg_q.press_delay_us};
      REG_REL_DLY:   prdata = {{(DataW-TimeW){1'b0}}, cfg_q.release_delay_us};
      REG_ENABLE:    prdata = {{(DataW-1){1'b0}}, cfg_q.enable};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dlt_fsm.sv =====
// trigger state: accumulators, button phase and held flag, one update per item
// depends on dlt_pkg
`default_nettype none

module dlt_fsm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire dlt_pkg::cfg_t  cfg_i,
  input  wire dlt_pkg::item_t item_i,
  output dlt_pkg::res_t      res_o
);
  import dlt_pkg::*;

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] above_q, above_d;
  logic [TimeW-1:0] below_q, below_d;
  logic             held_q, held_d;

  logic [LevelW-1:0] thr;
  logic              above;
  logic              disabled;
  logic [TimeW:0]    above_sum, below_sum;
  logic [TimeW-1:0]  above_sat, below_sat;
  phase_e            ph_eff;
  logic              press_ev, rel_ev;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      above_q <= '0;
      below_q <= '0;
      held_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      above_q <= above_d;
      below_q <= below_d;
      held_q  <= held_d;
    end
  end

  // threshold compare and saturating accumulators
  assign thr       = (cfg_i.threshold_level < ThreshFloor) ? ThreshFloor
                                                          : cfg_i.threshold_level;
  assign above     = item_i.level > thr;
  assign disabled  = !cfg_i.enable || !item_i.audio_ok;
  assign above_sum = {1'b0, above_q} + {{(TimeW+1-DtW){1'b0}}, item_i.elapsed_us};
  assign below_sum = {1'b0, below_q} + {{(TimeW+1-DtW){1'b0}}, item_i.elapsed_us};
  assign above_sat = above_sum[TimeW] ? TimeMax : above_sum[TimeW-1:0];
  assign below_sat = below_sum[TimeW] ? TimeMax : below_sum[TimeW-1:0];
  assign ph_eff    = item_i.dead ? PH_RELEASING : phase_q;

  // next state and events
  always_comb begin
    phase_d  = phase_q;
    above_d  = above ? above_sat : '0;
    below_d  = above ? '0 : below_sat;
    held_d   = held_q;
    press_ev = 1'b0;
    rel_ev   = 1'b0;
    if (disabled) begin
      rel_ev  = held_q;
      held_d  = 1'b0;
      phase_d = PH_IDLE;
      above_d = '0;
      below_d = '0;
    end else begin
      case (ph_eff)
        PH_IDLE: begin
          if (above && (above_d >= cfg_i.press_delay_us)) begin
            press_ev = !held_q;
            held_d   = 1'b1;
            phase_d  = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (above) begin
            phase_d = PH_HELD;
          end else if (below_d >= cfg_i.release_delay_us) begin
            phase_d = PH_RELEASING;
          end
        end
        PH_HELD: begin
          if (!above && (below_d >= cfg_i.release_delay_us)) begin
            phase_d = PH_RELEASING;
          end
        end
        default: begin
          rel_ev  = held_q;
          held_d  = 1'b0;
          phase_d = PH_IDLE;
          above_d = '0;
          below_d = '0;
        end
      endcase
    end
  end

  assign res_o.press_event   = press_ev;
  assign res_o.release_event = rel_ev;
  assign res_o.button_down   = held_d;
  assign res_o.phase_out     = phase_d;

endmodule

`default_nettype wire
